// ===== rtl/core/stereo_mixer_with_clip_playback_unit_assert.svh =====
// Assertion macros shared by the stereo mixer RTL.
// No dependencies; expects clk and rst in the scope of use.
`ifndef STEREO_MIXER_WITH_CLIP_PLAYBACK_UNIT_ASSERT_SVH
`define STEREO_MIXER_WITH_CLIP_PLAYBACK_UNIT_ASSERT_SVH

// same-cycle implication
`define SMCP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMCP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/smcp_pkg.sv =====
// Package for the stereo mixer with clip playback: constants, beat types, op codes.
// No dependencies.
package smcp_pkg;

  localparam int NUM_CLIPS   = 8;
  localparam int CLIP_BITS   = 3;
  localparam int CLIP_FRAMES = 65536;
  localparam int FRAME_BITS  = 16;
  localparam int LEN_BITS    = FRAME_BITS + 1;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int FRAC_BITS   = 12;
  localparam int STORE_ADDR_BITS = CLIP_BITS + FRAME_BITS;
  localparam int STORE_DEPTH = NUM_CLIPS * CLIP_FRAMES;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SUM_BITS    = PROD_BITS + 1;

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << FRAC_BITS);

  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_MIC     = 2'd2;

  localparam int REG_MIC_GAIN  = 0;
  localparam int REG_CLIP_GAIN = 1;
  localparam int REG_IDX_BITS  = 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [CLIP_BITS-1:0]  clip_number;
    logic [FRAME_BITS-1:0] frame_address;
    logic                  last_frame;
    sample_t               left_sample;
    sample_t               right_sample;
  } item_beat_t;

  typedef struct packed {
    sample_t mixed_left;
    sample_t mixed_right;
    logic    still_playing;
  } result_beat_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

endpackage

// ===== rtl/core/smcp_clip_store.sv =====
// Clip sample memory: one stereo frame per entry, one write and one registered read port.
// Depends on smcp_pkg.
module smcp_clip_store (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [smcp_pkg::STORE_ADDR_BITS-1:0] rd_addr,
  output smcp_pkg::frame_t                    rd_data,
  input  logic                                wr_en,
  input  logic [smcp_pkg::STORE_ADDR_BITS-1:0] wr_addr,
  input  smcp_pkg::frame_t                    wr_data
);
  import smcp_pkg::*;

  frame_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/smcp_lane.sv =====
// One mixing lane: two gain products, rounding and hard clip, two register stages.
// Depends on smcp_pkg.
module smcp_lane (
  input  logic                            clk,
  input  logic                            en,
  input  smcp_pkg::sample_t               mic,
  input  smcp_pkg::sample_t               clip,
  input  logic                            use_clip,
  input  logic [smcp_pkg::GAIN_BITS-1:0]  mic_gain,
  input  logic [smcp_pkg::GAIN_BITS-1:0]  clip_gain,
  output smcp_pkg::sample_t               mixed
);
  import smcp_pkg::*;

  localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1 << (FRAC_BITS - 1));

  logic signed [PROD_BITS-1:0] prod_mic;
  logic signed [PROD_BITS-1:0] prod_clip;
  sample_t                     clip_sel;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  quo;

  assign clip_sel = use_clip ? clip : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_mic  <= mic * $signed({1'b0, mic_gain});
      prod_clip <= clip_sel * $signed({1'b0, clip_gain});
    end
  end

  assign sum = SUM_BITS'(prod_mic) + SUM_BITS'(prod_clip) + ROUND_HALF;
  assign quo = sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      if (quo > SUM_BITS'(SAT_MAX)) begin
        mixed <= SAT_MAX;
      end else if (quo < SUM_BITS'(SAT_MIN)) begin
        mixed <= SAT_MIN;
      end else begin
        mixed <= quo[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/stereo_mixer_with_clip_playback_unit.sv =====
// Top level of the stereo mixer with clip playback: playback control, pipeline, APB regs.
// Depends on smcp_pkg, smcp_clip_store, smcp_lane and the assertion macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  item     | item_valid/item_stall | op, clip, address, last, left/right sample
//  result   | result_valid/..stall  | mixed left/right, still_playing
//  config   | APB psel/penable     | mic_gain @0x0, clip_gain @0x4
//
// One beat per cycle while the result channel is not stalled; a mic beat's result is
// registered in turn by the clip memory read, the product register and the round/clip register.
// Reset: synchronous rst clears control, lengths and gains; the clip memory is
// not cleared and needs no clearing pass.
// A stalled result freezes the whole pipeline and stalls the item channel.
module stereo_mixer_with_clip_playback_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  smcp_pkg::item_beat_t     item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output smcp_pkg::result_beat_t   result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import smcp_pkg::*;

  `include "stereo_mixer_with_clip_playback_unit_assert.svh"

  logic [GAIN_BITS-1:0] mic_gain;
  logic [GAIN_BITS-1:0] clip_gain;
  logic [REG_IDX_BITS-1:0] reg_idx;

  logic [LEN_BITS-1:0]  clip_lengths [NUM_CLIPS];
  logic [CLIP_BITS-1:0] active_clip;
  logic [LEN_BITS-1:0]  read_position;
  logic                 playing;

  logic adv, acc, clip_ok, addr_ok, use_clip;
  logic is_load, is_trigger, is_mic;

  logic    s1_valid, s1_use, s1_still;
  sample_t s1_mic_l, s1_mic_r;
  logic    s2_valid, s2_still;
  logic    s3_still;
  frame_t  rd_frame, wr_frame;
  sample_t lane_l, lane_r;

  // APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign prdata  = (reg_idx == REG_IDX_BITS'(REG_CLIP_GAIN)) ? 32'(clip_gain) : 32'(mic_gain);

  always_ff @(posedge clk) begin
    if (rst) begin
      mic_gain  <= GAIN_UNITY;
      clip_gain <= GAIN_UNITY;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_IDX_BITS'(REG_MIC_GAIN):  mic_gain  <= pwdata[GAIN_BITS-1:0];
        REG_IDX_BITS'(REG_CLIP_GAIN): clip_gain <= pwdata[GAIN_BITS-1:0];
        default:                      mic_gain  <= mic_gain;
      endcase
    end
  end

  // handshake
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;
  assign acc        = item_valid && adv;

  assign is_load    = acc && (item.op == OP_LOAD);
  assign is_trigger = acc && (item.op == OP_TRIGGER);
  assign is_mic     = acc && (item.op == OP_MIC);
  assign clip_ok    = {1'b0, item.clip_number} < (CLIP_BITS + 1)'(NUM_CLIPS);
  assign addr_ok    = {1'b0, item.frame_address} < LEN_BITS'(CLIP_FRAMES);
  assign use_clip   = playing && (read_position < clip_lengths[active_clip]);

  // playback control
  always_ff @(posedge clk) begin
    if (rst) begin
      active_clip   <= '0;
      read_position <= '0;
      playing       <= 1'b0;
      for (int i = 0; i < NUM_CLIPS; i++) begin
        clip_lengths[i] <= '0;
      end
    end else begin
      if (is_load && clip_ok) begin
        read_position <= '0;
        if (addr_ok && item.last_frame) begin
          clip_lengths[item.clip_number] <= LEN_BITS'(item.frame_address) + 1'b1;
        end
      end
      if (is_trigger && clip_ok) begin
        active_clip   <= item.clip_number;
        read_position <= '0;
        playing       <= 1'b1;
      end
      if (is_mic) begin
        if (use_clip) begin
          read_position <= read_position + 1'b1;
        end else begin
          playing <= 1'b0;
        end
      end
    end
  end

  assign wr_frame = '{left: item.left_sample, right: item.right_sample};

  smcp_clip_store u_store (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr ({active_clip, read_position[FRAME_BITS-1:0]}),
    .rd_data (rd_frame),
    .wr_en   (is_load && clip_ok && addr_ok),
    .wr_addr ({item.clip_number, item.frame_address}),
    .wr_data (wr_frame)
  );

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= is_mic;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mic_l <= item.left_sample;
      s1_mic_r <= item.right_sample;
      s1_use   <= use_clip;
      s1_still <= use_clip;
      s2_still <= s1_still;
      s3_still <= s2_still;
    end
  end

  smcp_lane u_lane_l (
    .clk       (clk),
    .en        (adv),
    .mic       (s1_mic_l),
    .clip      (rd_frame.left),
    .use_clip  (s1_use),
    .mic_gain  (mic_gain),
    .clip_gain (clip_gain),
    .mixed     (lane_l)
  );

  smcp_lane u_lane_r (
    .clk       (clk),
    .en        (adv),
    .mic       (s1_mic_r),
    .clip      (rd_frame.right),
    .use_clip  (s1_use),
    .mic_gain  (mic_gain),
    .clip_gain (clip_gain),
    .mixed     (lane_r)
  );

  // merge lanes
  assign result = '{mixed_left: lane_l, mixed_right: lane_r, still_playing: s3_still};

  `SMCP_CHECK_NEXT(a_load_rewinds, is_load && clip_ok, read_position == '0, "load did not rewind")
  `SMCP_CHECK_NEXT(a_still_matches, is_mic, s1_still == playing, "still flag differs from state")
  `SMCP_CHECK(a_pos_in_clip, playing, read_position <= clip_lengths[active_clip], "position past clip end")
  `SMCP_CHECK_NEXT(a_end_stops, is_mic && !use_clip, !playing, "playback not stopped at clip end")

endmodule

// ===== tb/stereo_mixer_with_clip_playback_unit_tb.sv =====
// Self-checking testbench for stereo_mixer_with_clip_playback_unit: directed table, then
// random clip load/trigger/play runs under several gain settings and idle patterns.
// Depends on smcp_pkg and the unit under test; needs nothing else.
`timescale 1ns / 100ps

module stereo_mixer_with_clip_playback_unit_tb;
  import smcp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    item_beat_t   beat;
    bit           typed;
    result_beat_t want;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_stall;
  item_beat_t   item;
  logic         result_valid;
  logic         result_stall;
  result_beat_t result;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // mixer state as predicted
  sample_t               clip_left [int];
  sample_t               clip_right [int];
  logic [LEN_BITS-1:0]   clip_len [NUM_CLIPS];
  logic [CLIP_BITS-1:0]  active_clip;
  logic [LEN_BITS-1:0]   play_pos;
  bit                    playing;
  logic [GAIN_BITS-1:0]  mic_gain_q;
  logic [GAIN_BITS-1:0]  clip_gain_q;

  result_beat_t pending_mixes [$];
  dir_row_t     dir_rows [$];
  idle_mode_e   idle_mode = IDLE_NONE;
  int           errors = 0;
  int           items_sent = 0;
  int           hold_request = 0;
  int           hold_left = 0;

  stereo_mixer_with_clip_playback_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic sample_t round_sat(longint acc);
    longint q;
    q = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > longint'(SAT_MAX)) return SAT_MAX;
    if (q < longint'(SAT_MIN)) return SAT_MIN;
    return sample_t'(q);
  endfunction

  task automatic predict_mix(input item_beat_t b, output bit has, output result_beat_t r);
    longint acc_l;
    longint acc_r;
    int key;
    has = 1'b0;
    r = '0;
    case (b.op)
      OP_LOAD: begin
        key = int'(b.clip_number) * CLIP_FRAMES + int'(b.frame_address);
        clip_left[key] = b.left_sample;
        clip_right[key] = b.right_sample;
        if (b.last_frame) clip_len[b.clip_number] = LEN_BITS'(b.frame_address) + 1'b1;
        play_pos = '0;
      end
      OP_TRIGGER: begin
        active_clip = b.clip_number;
        play_pos = '0;
        playing = 1'b1;
      end
      OP_MIC: begin
        acc_l = longint'(b.left_sample) * longint'(mic_gain_q);
        acc_r = longint'(b.right_sample) * longint'(mic_gain_q);
        if (playing) begin
          if (play_pos < clip_len[active_clip]) begin
            key = int'(active_clip) * CLIP_FRAMES + int'(play_pos);
            acc_l += longint'(clip_left[key]) * longint'(clip_gain_q);
            acc_r += longint'(clip_right[key]) * longint'(clip_gain_q);
            play_pos = play_pos + 1'b1;
          end else begin
            playing = 1'b0;
          end
        end
        r.mixed_left = round_sat(acc_l);
        r.mixed_right = round_sat(acc_r);
        r.still_playing = playing;
        has = 1'b1;
      end
      default: ;
    endcase
  endtask

  // frames 0..n-1 of a clip all loaded; a last mark at or below n keeps every
  // frame under the clip length defined
  function automatic int loaded_prefix(int c);
    int n;
    n = 0;
    while (n < CLIP_FRAMES && clip_left.exists(c * CLIP_FRAMES + n)) n++;
    return n;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 68;
      IDLE_BOTH: return $urandom_range(0, 99) < 16;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 68;
      IDLE_BOTH: return $urandom_range(0, 99) < 16;
      default: return 1'b0;
    endcase
  endfunction

  function automatic dir_row_t row(logic [1:0] op, int clip, int addr, bit last,
                                   sample_t l, sample_t r, bit typed = 1'b0,
                                   sample_t wl = '0, sample_t wr = '0, bit wp = 1'b0);
    dir_row_t d;
    d.beat.op = op;
    d.beat.clip_number = CLIP_BITS'(clip);
    d.beat.frame_address = FRAME_BITS'(addr);
    d.beat.last_frame = last;
    d.beat.left_sample = l;
    d.beat.right_sample = r;
    d.typed = typed;
    d.want.mixed_left = wl;
    d.want.mixed_right = wr;
    d.want.still_playing = wp;
    return d;
  endfunction

  task automatic send_item(input item_beat_t b, input bit typed, input result_beat_t want);
    bit has;
    result_beat_t r;
    while (sender_idles()) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= b;
    do @(posedge clk); while (!(item_valid && !item_stall));
    predict_mix(b, has, r);
    if (has) pending_mixes.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic send_mic();
    item_beat_t b;
    b.op = OP_MIC;
    b.clip_number = CLIP_BITS'($urandom);
    b.frame_address = FRAME_BITS'($urandom);
    b.last_frame = 1'($urandom);
    b.left_sample = rand_sample();
    b.right_sample = rand_sample();
    send_item(b, 1'b0, '0);
  endtask

  task automatic send_noise();
    item_beat_t b;
    int c;
    c = $urandom_range(0, NUM_CLIPS - 1);
    b.clip_number = CLIP_BITS'(c);
    b.frame_address = FRAME_BITS'($urandom);
    b.last_frame = 1'($urandom);
    b.left_sample = rand_sample();
    b.right_sample = rand_sample();
    case ($urandom_range(0, 3))
      0: b.op = OP_UNUSED;
      1: begin
        b.op = OP_LOAD;
        if ($urandom_range(0, 2) != 0) begin
          b.frame_address = FRAME_BITS'($urandom_range(0, loaded_prefix(c)));
        end else begin
          b.last_frame = 1'b0;
        end
      end
      2: b.op = OP_TRIGGER;
      default: b.op = OP_MIC;
    endcase
    send_item(b, 1'b0, '0);
  endtask

  // load a short clip, trigger it in most runs, then send mic beats (some noise) for its length plus up to three
  task automatic play_clip_run();
    item_beat_t b;
    int c;
    int len;
    int frames;
    c = $urandom_range(0, NUM_CLIPS - 1);
    len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
    for (int a = 0; a < len; a++) begin
      b.op = OP_LOAD;
      b.clip_number = CLIP_BITS'(c);
      b.frame_address = FRAME_BITS'(a);
      b.last_frame = (a == len - 1);
      b.left_sample = rand_sample();
      b.right_sample = rand_sample();
      send_item(b, 1'b0, '0);
    end
    if ($urandom_range(0, 9) != 0) begin
      b.op = OP_TRIGGER;
      b.frame_address = FRAME_BITS'($urandom);
      b.last_frame = 1'($urandom);
      send_item(b, 1'b0, '0);
    end
    frames = len + $urandom_range(0, 3);
    for (int i = 0; i < frames; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_mic();
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [GAIN_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MIC_GAIN) mic_gain_q = value;
    else clip_gain_q = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value)) begin
      $error("prdata: expected %0d, got %0d", value, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    if (pending_mixes.size() == 0) begin
      $error("result beat with no expectation pending");
      errors++;
      return;
    end
    want = pending_mixes.pop_front();
    if (got.mixed_left !== want.mixed_left) begin
      $error("mixed_left: expected %0d, got %0d", want.mixed_left, got.mixed_left);
      errors++;
    end
    if (got.mixed_right !== want.mixed_right) begin
      $error("mixed_right: expected %0d, got %0d", want.mixed_right, got.mixed_right);
      errors++;
    end
    if (got.still_playing !== want.still_playing) begin
      $error("still_playing: expected %0d, got %0d", want.still_playing,
             got.still_playing);
      errors++;
    end
  endtask

  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) check_result(result);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= receiver_stalls();
      end
    end
  end

  initial begin
    logic [GAIN_BITS-1:0] mg;
    logic [GAIN_BITS-1:0] cg;
    int target;
    int runs;

    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int c = 0; c < NUM_CLIPS; c++) clip_len[c] = '0;
    active_clip = '0;
    play_pos = '0;
    playing = 1'b0;
    mic_gain_q = GAIN_UNITY;
    clip_gain_q = GAIN_UNITY;

    // op, clip, address, last, left, right [, typed, want left, want right, want playing]
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, SAT_MAX, SAT_MAX, 1, SAT_MAX, SAT_MAX, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, SAT_MIN, SAT_MIN, 1, SAT_MIN, SAT_MIN, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 0, -1, 1, 0, -1, 0));
    dir_rows.push_back(row(OP_UNUSED, 7, 16'hFFFF, 1, -1, -1));
    dir_rows.push_back(row(OP_TRIGGER, 2, 0, 0, 0, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 123, -456, 1, 123, -456, 0));
    dir_rows.push_back(row(OP_LOAD, 1, 0, 0, SAT_MAX, SAT_MIN));
    dir_rows.push_back(row(OP_TRIGGER, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 5, 6, 1, 5, 6, 0));
    dir_rows.push_back(row(OP_LOAD, 1, 1, 1, 1000, -1000));
    dir_rows.push_back(row(OP_LOAD, 1, 16'hFFFF, 0, 777, -777));
    dir_rows.push_back(row(OP_TRIGGER, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, SAT_MAX, SAT_MIN, 1, SAT_MAX, SAT_MIN, 1));
    dir_rows.push_back(row(OP_LOAD, 1, 1, 1, 500, -500));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 0, 0, 1, SAT_MAX, SAT_MIN, 1));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 0, 0, 1, 500, -500, 1));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 100, -100, 1, 100, -100, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 7, 7, 1, 7, 7, 0));
    dir_rows.push_back(row(OP_TRIGGER, 7, 0, 0, 0, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, -8, 8, 1, -8, 8, 0));
    dir_rows.push_back(row(OP_TRIGGER, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, SAT_MIN, SAT_MAX, 1, -1, -1, 1));
    dir_rows.push_back(row(OP_MIC, 0, 0, 0, 3, 4));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mg = GAIN_UNITY; cg = GAIN_UNITY; end
        1: begin mg = '0; cg = '1; end
        2: begin mg = '1; cg = '0; end
        3: begin mg = '1; cg = '1; end
        4: begin mg = 16'd1; cg = 16'h0800; end
        default: begin mg = GAIN_BITS'($urandom); cg = GAIN_BITS'($urandom); end
      endcase
      write_reg(REG_MIC_GAIN, mg);
      write_reg(REG_CLIP_GAIN, cg);
      idle_mode = idle_mode_e'(p % 4);
      if (p == 2) hold_request = 300;
      target = items_sent + ITEMS_PER_PHASE;
      runs = 0;
      while (items_sent < target) begin
        if ($urandom_range(0, 3) != 0) play_clip_run();
        else send_noise();
        runs++;
        if (p == 5 && runs == 3) wait_drained();
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/smcp_pkg.sv
rtl/core/smcp_clip_store.sv
rtl/core/smcp_lane.sv
rtl/core/stereo_mixer_with_clip_playback_unit.sv
tb/stereo_mixer_with_clip_playback_unit_tb.sv
